FILE: rtl/pfte_pkg.sv
// ----------------------------------------------------------------------------
// pfte_pkg
// Shared types, constants and the 5x8 font for the page framebuffer engine.
// ----------------------------------------------------------------------------
package pfte_pkg;

    localparam int DISP_COLS    = 128;
    localparam int SCREEN_ROWS  = 64;
    localparam int PAGE_COUNT   = SCREEN_ROWS / 8;
    localparam int STORE_BYTES  = DISP_COLS * PAGE_COUNT;
    localparam int ADDR_W       = $clog2(STORE_BYTES);
    localparam int GLYPH_COLS   = 5;
    localparam int GLYPH_PITCH  = 5 + 1;
    localparam int FIRST_CODE   = 32;
    localparam int LAST_CODE    = 126;
    localparam int FALLBACK     = 63;

    localparam logic [2:0] K_CLEAR  = 3'd0;
    localparam logic [2:0] K_PIXEL  = 3'd1;
    localparam logic [2:0] K_GLYPH  = 3'd2;
    localparam logic [2:0] K_START  = 3'd3;
    localparam logic [2:0] K_CHAR   = 3'd4;
    localparam logic [2:0] K_READ   = 3'd5;
    localparam logic [2:0] K_RSVD_A = 3'd6;
    localparam logic [2:0] K_RSVD_B = 3'd7;

    localparam logic [1:0] ST_DONE     = 2'd0;
    localparam logic [1:0] ST_IGNORED  = 2'd1;
    localparam logic [1:0] ST_OVERFLOW = 2'd2;

    typedef struct packed {
        logic [2:0] kind;
        logic [7:0] pixel_x;
        logic [7:0] pixel_y;
        logic       pixel_on;
        logic [7:0] page_row;
        logic [7:0] char_code;
        logic [9:0] byte_index;
    } t_in;

    typedef struct packed {
        logic [1:0] status;
        logic [7:0] read_data;
    } t_out;

    localparam logic [39:0] FONT [95] = '{
        40'h0000000000, 40'h00005F0000, 40'h0007000700, 40'h147F147F14,
        40'h242A7F2A12, 40'h2313086462, 40'h3649552250, 40'h0005030000,
        40'h001C224100, 40'h0041221C00, 40'h14083E0814, 40'h08083E0808,
        40'h0050300000, 40'h0808080808, 40'h0060600000, 40'h2010080402,
        40'h3E5149453E, 40'h00427F4000, 40'h4261514946, 40'h2141454B31,
        40'h1814127F10, 40'h2745454539, 40'h3C4A494930, 40'h0171090503,
        40'h3649494936, 40'h064949291E, 40'h0036360000, 40'h0056360000,
        40'h0814224100, 40'h1414141414, 40'h0041221408, 40'h0201510906,
        40'h324979413E, 40'h7E1111117E, 40'h7F49494936, 40'h3E41414122,
        40'h7F4141221C, 40'h7F49494941, 40'h7F09090901, 40'h3E4149497A,
        40'h7F0808087F, 40'h00417F4100, 40'h2040413F01, 40'h7F08142241,
        40'h7F40404040, 40'h7F020C027F, 40'h7F0408107F, 40'h3E4141413E,
        40'h7F09090906, 40'h3E4151215E, 40'h7F09192946, 40'h4649494931,
        40'h01017F0101, 40'h3F4040403F, 40'h1F2040201F, 40'h3F4038403F,
        40'h6314081463, 40'h0708700807, 40'h6151494543, 40'h007F414100,
        40'h0204081020, 40'h0041417F00, 40'h0402010204, 40'h4040404040,
        40'h0001020400, 40'h2054545478, 40'h7F48444438, 40'h3844444420,
        40'h384444487F, 40'h3854545418, 40'h087E090102, 40'h0C5252523E,
        40'h7F08040478, 40'h00447D4000, 40'h2040443D00, 40'h7F10284400,
        40'h00417F4000, 40'h7C04180478, 40'h7C08040478, 40'h3844444438,
        40'h7C14141408, 40'h081414187C, 40'h7C08040408, 40'h4854545420,
        40'h043F444020, 40'h3C4040207C, 40'h1C2040201C, 40'h3C4030403C,
        40'h4428102844, 40'h0C5050503C, 40'h4464544C44, 40'h0008364100,
        40'h00007F0000, 40'h0041360800, 40'h0201020402
    };

endpackage

FILE: rtl/pfte_ram.sv
// ----------------------------------------------------------------------------
// pfte_ram
// Generic single-port RAM with registered read.
// ----------------------------------------------------------------------------
module pfte_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule

FILE: rtl/page_framebuffer_text_engine.sv
// ----------------------------------------------------------------------------
// page_framebuffer_text_engine
// Paged monochrome framebuffer with clear, pixel, glyph, text and byte-read items.
// ----------------------------------------------------------------------------
// One transaction at a time: busy is high from the accepting edge until the
// result strobe has gone. Text start, unused kinds and rejected items give
// their result straight from idle. Pixel write and byte read pass through a
// read state and a modify state on the single RAM port (a pixel write reads,
// modifies and writes back; a byte read only reads). Glyph and text char write
// five columns one per cycle, skipped columns included, then a closing state.
// Clear sweeps the store one byte a cycle. The same sweep runs after reset,
// keeping busy high; start is refused during the pass.
// The result strobe o_done cannot be held off by the receiver.
module page_framebuffer_text_engine (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            start,
    output logic            busy,
    input  pfte_pkg::t_in   i_item,
    output logic            o_done,
    output pfte_pkg::t_out  o_result
);
    import pfte_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_SWEEP = 6'b000010,
        S_RD    = 6'b000100,
        S_MOD   = 6'b001000,
        S_GLYPH = 6'b010000,
        S_FIN   = 6'b100000
    } t_state;

    t_state            r_state, n_state;
    logic [ADDR_W:0]   r_cnt, n_cnt;
    logic [ADDR_W-1:0] r_addr, n_addr;
    logic [8:0]        r_col, n_col;
    logic [39:0]       r_glyph, n_glyph;
    logic [7:0]        r_mask, n_mask;
    logic              r_on, n_on, r_isread, n_isread;
    logic [1:0]        r_status, n_status;
    logic [7:0]        r_cur_col, n_cur_col;
    logic [2:0]        r_cur_page, n_cur_page;
    logic              r_cur_valid, n_cur_valid;
    logic              r_done, n_done;
    t_out              r_res, n_res;
    // marks a sweep that an accepted clear started, not the reset pass
    logic              r_startd;

    logic              we;
    logic [ADDR_W-1:0] ram_addr;
    logic [7:0]        wdata, rdata;

    pfte_ram #(.WIDTH(8), .DEPTH(STORE_BYTES)) u_ram (
        .i_clk(i_clk), .i_we(we), .i_addr(ram_addr), .i_wdata(wdata), .o_rdata(rdata)
    );

    function automatic logic [39:0] glyph_of(input logic [7:0] code);
        logic [7:0] c;
        c = (code < 8'(FIRST_CODE) || code > 8'(LAST_CODE)) ? 8'(FALLBACK) : code;
        return FONT[7'(c - 8'(FIRST_CODE))];
    endfunction

    always_comb begin
        n_state = r_state; n_cnt = r_cnt; n_addr = r_addr; n_col = r_col;
        n_glyph = r_glyph; n_mask = r_mask; n_on = r_on; n_isread = r_isread;
        n_status = r_status; n_cur_col = r_cur_col; n_cur_page = r_cur_page;
        n_cur_valid = r_cur_valid; n_done = 1'b0; n_res = r_res;
        we = 1'b0; ram_addr = r_addr; wdata = 8'h00;
        unique case (r_state)
            S_IDLE: begin
                // hold off a new transaction while the result strobe is out
                if (start && !r_done) begin
                    n_res = '0;
                    unique case (i_item.kind)
                        K_CLEAR: begin
                            n_cnt = '0; n_state = S_SWEEP; n_status = ST_DONE;
                        end
                        K_PIXEL: begin
                            if (i_item.pixel_x >= 8'(DISP_COLS)
                                    || 9'(i_item.pixel_y) >= 9'(SCREEN_ROWS)) begin
                                n_res.status = ST_IGNORED; n_done = 1'b1;
                            end else begin
                                n_addr = ADDR_W'(ADDR_W'(i_item.pixel_x)
                                    + ADDR_W'(i_item.pixel_y[7:3]) * ADDR_W'(DISP_COLS));
                                n_mask = 8'(1) << i_item.pixel_y[2:0];
                                n_on = i_item.pixel_on; n_isread = 1'b0;
                                n_state = S_RD;
                            end
                        end
                        K_READ: begin
                            if (11'(i_item.byte_index) >= 11'(STORE_BYTES)) begin
                                n_res.status = ST_IGNORED; n_done = 1'b1;
                            end else begin
                                n_addr = ADDR_W'(i_item.byte_index);
                                n_isread = 1'b1; n_state = S_RD;
                            end
                        end
                        K_GLYPH: begin
                            if (9'(i_item.page_row) >= 9'(PAGE_COUNT)) begin
                                n_res.status = ST_IGNORED; n_done = 1'b1;
                            end else begin
                                n_col = 9'(i_item.pixel_x);
                                n_cur_page = n_cur_page;
                                n_addr = ADDR_W'(ADDR_W'(i_item.page_row)
                                    * ADDR_W'(DISP_COLS));
                                n_glyph = glyph_of(i_item.char_code);
                                n_cnt = '0; n_status = ST_DONE; n_state = S_GLYPH;
                            end
                        end
                        K_START: begin
                            if (9'(i_item.page_row) >= 9'(PAGE_COUNT)) begin
                                n_cur_valid = 1'b0; n_res.status = ST_IGNORED;
                            end else begin
                                n_cur_col = i_item.pixel_x;
                                n_cur_page = 3'(i_item.page_row);
                                n_cur_valid = 1'b1;
                            end
                            n_done = 1'b1;
                        end
                        K_CHAR: begin
                            if (!r_cur_valid) begin
                                n_res.status = ST_IGNORED; n_done = 1'b1;
                            end else if (9'(r_cur_col) + 9'(GLYPH_COLS)
                                    >= 9'(DISP_COLS)) begin
                                n_res.status = ST_OVERFLOW; n_done = 1'b1;
                            end else begin
                                n_col = 9'(r_cur_col);
                                n_addr = ADDR_W'(ADDR_W'(r_cur_page)
                                    * ADDR_W'(DISP_COLS));
                                n_glyph = glyph_of(i_item.char_code);
                                n_cur_col = 8'(r_cur_col + 8'(GLYPH_PITCH));
                                n_cnt = '0; n_status = ST_DONE; n_state = S_GLYPH;
                            end
                        end
                        default: begin
                            n_res.status = ST_IGNORED; n_done = 1'b1;
                        end
                    endcase
                end
            end
            S_SWEEP: begin
                we = 1'b1; ram_addr = r_cnt[ADDR_W-1:0];
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == (ADDR_W+1)'(STORE_BYTES - 1)) begin
                    n_state = S_FIN;
                end
            end
            S_RD: n_state = S_MOD;
            S_MOD: begin
                if (r_isread) begin
                    n_res.read_data = rdata;
                end else begin
                    we = 1'b1;
                    wdata = r_on ? (rdata | r_mask) : (rdata & ~r_mask);
                end
                n_res.status = ST_DONE; n_done = 1'b1; n_state = S_IDLE;
            end
            S_GLYPH: begin
                // skip columns past the right edge
                if (r_col + 9'(r_cnt[2:0]) < 9'(DISP_COLS)) begin
                    we = 1'b1;
                    ram_addr = ADDR_W'(r_addr + ADDR_W'(r_col) + ADDR_W'(r_cnt[2:0]));
                    wdata = r_glyph[39:32];
                end
                n_glyph = {r_glyph[31:0], 8'h00};
                n_cnt = r_cnt + 1'b1;
                if (r_cnt[2:0] == 3'(GLYPH_COLS - 1)) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                n_res.status = r_status; n_done = 1'b1;
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_SWEEP; r_cnt <= '0; r_cur_col <= '0; r_cur_page <= '0;
            r_cur_valid <= 1'b0; r_done <= 1'b0; r_isread <= 1'b0;
            r_status <= ST_DONE;
        end else begin
            r_state <= n_state; r_cnt <= n_cnt; r_cur_col <= n_cur_col;
            r_cur_page <= n_cur_page; r_cur_valid <= n_cur_valid;
            r_isread <= n_isread; r_status <= n_status;
            // reset sweep ends without a result
            r_done <= n_done & ~(r_state == S_FIN && !r_startd);
        end
        r_addr <= n_addr; r_col <= n_col; r_glyph <= n_glyph; r_mask <= n_mask;
        r_on <= n_on; r_res <= n_res;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_startd <= 1'b0;
        end else if (r_state == S_IDLE) begin
            r_startd <= start;
        end
    end

    assign busy     = (r_state != S_IDLE) || r_done;
    assign o_done   = r_done;
    assign o_result = r_res;

    a_no_start_when_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !(start && !busy))
        else $error("item accepted while working");
    a_done_goes_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> r_state == S_IDLE)
        else $error("result while working");
    a_done_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("result repeated");
endmodule
